### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/icfe_pkg.sv
package icfe_pkg;

  localparam int SIDE_DEF = 16;

  localparam int COORD_W = 4;
  localparam int SIZE_W = 13;
  localparam int MAG_W = 14;
  localparam int ENG_W = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [31:0] THRESH_RST = 32'd1583600000;
  localparam logic [31:0] SEED_RST = 32'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED = 2'd1;

  localparam logic [1:0] KIND_WR = 2'd0;
  localparam logic [1:0] KIND_RD = 2'd1;
  localparam logic [1:0] KIND_UPD = 2'd2;
  localparam logic [1:0] KIND_MEAS = 2'd3;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_WR,
    S_RD,
    S_SEED_RD,
    S_SEED_WR,
    S_POP,
    S_POP_TAKE,
    S_NB_RD,
    S_NB_CHK,
    S_FLIP_RD,
    S_FLIP_WR,
    S_M_RD0,
    S_M_RD1,
    S_M_RD2,
    S_M_RD3,
    S_M_ACC,
    S_FIN
  } state_t;

  typedef struct packed {
    logic       load_in;
    logic       clr_wr;
    logic       wr_spin;
    logic       rd_site;
    logic       seed_wr;
    logic       pop_rd;
    logic       pop_take;
    logic       nb_rd;
    logic       nb_chk;
    logic       flip_rd;
    logic       flip_wr;
    logic       m_rd;
    logic [1:0] m_sel;
    logic       m_acc;
    logic       fin;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic queue_empty;
    logic dir_last;
    logic k_last;
    logic site_last;
    logic out_free;
  } sts_t;

endpackage

### hdl/icfe_ctrl.sv
module icfe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        kind,
  input  icfe_pkg::sts_t    sts,
  output icfe_pkg::cmd_t    cmd
);

  icfe_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= icfe_pkg::S_CLR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == icfe_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      icfe_pkg::S_CLR: begin
        if (sts.clr_last) state_next = icfe_pkg::S_IDLE;
      end
      icfe_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (kind)
            icfe_pkg::KIND_WR:  state_next = icfe_pkg::S_WR;
            icfe_pkg::KIND_RD:  state_next = icfe_pkg::S_RD;
            icfe_pkg::KIND_UPD: state_next = icfe_pkg::S_SEED_RD;
            default:            state_next = icfe_pkg::S_M_RD0;
          endcase
        end
      end
      icfe_pkg::S_WR:       state_next = icfe_pkg::S_FIN;
      icfe_pkg::S_RD:       state_next = icfe_pkg::S_FIN;
      icfe_pkg::S_SEED_RD:  state_next = icfe_pkg::S_SEED_WR;
      icfe_pkg::S_SEED_WR:  state_next = icfe_pkg::S_POP;
      icfe_pkg::S_POP: begin
        state_next = sts.queue_empty ? icfe_pkg::S_FLIP_RD : icfe_pkg::S_POP_TAKE;
      end
      icfe_pkg::S_POP_TAKE: state_next = icfe_pkg::S_NB_RD;
      icfe_pkg::S_NB_RD:    state_next = icfe_pkg::S_NB_CHK;
      icfe_pkg::S_NB_CHK: begin
        state_next = sts.dir_last ? icfe_pkg::S_POP : icfe_pkg::S_NB_RD;
      end
      icfe_pkg::S_FLIP_RD:  state_next = icfe_pkg::S_FLIP_WR;
      icfe_pkg::S_FLIP_WR: begin
        state_next = sts.k_last ? icfe_pkg::S_FIN : icfe_pkg::S_FLIP_RD;
      end
      icfe_pkg::S_M_RD0:    state_next = icfe_pkg::S_M_RD1;
      icfe_pkg::S_M_RD1:    state_next = icfe_pkg::S_M_RD2;
      icfe_pkg::S_M_RD2:    state_next = icfe_pkg::S_M_RD3;
      icfe_pkg::S_M_RD3:    state_next = icfe_pkg::S_M_ACC;
      icfe_pkg::S_M_ACC: begin
        state_next = sts.site_last ? icfe_pkg::S_FIN : icfe_pkg::S_M_RD0;
      end
      icfe_pkg::S_FIN: begin
        if (sts.out_free) state_next = icfe_pkg::S_IDLE;
      end
      default: state_next = icfe_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      icfe_pkg::S_CLR:      cmd.clr_wr = 1'b1;
      icfe_pkg::S_IDLE:     cmd.load_in = in_valid;
      icfe_pkg::S_WR:       cmd.wr_spin = 1'b1;
      icfe_pkg::S_RD:       cmd.rd_site = 1'b1;
      icfe_pkg::S_SEED_RD:  cmd.rd_site = 1'b1;
      icfe_pkg::S_SEED_WR:  cmd.seed_wr = 1'b1;
      icfe_pkg::S_POP:      cmd.pop_rd = !sts.queue_empty;
      icfe_pkg::S_POP_TAKE: cmd.pop_take = 1'b1;
      icfe_pkg::S_NB_RD:    cmd.nb_rd = 1'b1;
      icfe_pkg::S_NB_CHK:   cmd.nb_chk = 1'b1;
      icfe_pkg::S_FLIP_RD:  cmd.flip_rd = 1'b1;
      icfe_pkg::S_FLIP_WR:  cmd.flip_wr = 1'b1;
      icfe_pkg::S_M_RD0: begin
        cmd.m_rd = 1'b1;
        cmd.m_sel = 2'd0;
      end
      icfe_pkg::S_M_RD1: begin
        cmd.m_rd = 1'b1;
        cmd.m_sel = 2'd1;
      end
      icfe_pkg::S_M_RD2: begin
        cmd.m_rd = 1'b1;
        cmd.m_sel = 2'd2;
      end
      icfe_pkg::S_M_RD3: begin
        cmd.m_rd = 1'b1;
        cmd.m_sel = 2'd3;
      end
      icfe_pkg::S_M_ACC:    cmd.m_acc = 1'b1;
      icfe_pkg::S_FIN:      cmd.fin = sts.out_free;
      default:              cmd = '0;
    endcase
  end

endmodule

### hdl/icfe_dpath.sv
module icfe_dpath #(
  parameter int SIDE = icfe_pkg::SIDE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  icfe_pkg::cmd_t                       cmd,
  output icfe_pkg::sts_t                       sts,
  input  logic [1:0]                           kind,
  input  logic [icfe_pkg::COORD_W-1:0]         site_x,
  input  logic [icfe_pkg::COORD_W-1:0]         site_y,
  input  logic [icfe_pkg::COORD_W-1:0]         site_z,
  input  logic                                 spin_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 spin_out,
  output logic [icfe_pkg::SIZE_W-1:0]          cluster_size,
  output logic signed [icfe_pkg::MAG_W-1:0]    magnet_sum,
  output logic signed [icfe_pkg::ENG_W-1:0]    bond_energy_sum,
  input  logic                                 cfg_valid,
  input  logic [icfe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [icfe_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CW = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam int NS = SIDE * SIDE * SIDE;
  localparam int AW = $clog2(NS);
  localparam int CNTW = AW + 1;
  localparam int QW = 3 * CW;

  // bit 1 visited, bit 0 spin
  logic [1:0]    lat_mem [NS];
  logic [QW-1:0] queue_mem [NS];

  logic [1:0]    kind_r;
  logic [CW-1:0] sx, sy, sz;
  logic          spin_r;
  logic [31:0]   thresh;
  logic [31:0]   rng_word;
  logic          cspin;
  logic [CNTW-1:0] head, tail, k;
  logic [CW-1:0] cx, cy, cz;
  logic [2:0]    dir;
  logic [CW-1:0] mx, my, mz;
  logic          s_q, nx_q, ny_q;
  logic signed [icfe_pkg::MAG_W-1:0] mag;
  logic signed [icfe_pkg::ENG_W-1:0] eng;
  logic [AW-1:0] clr_cnt;
  logic [1:0]    mem_q;
  logic [QW-1:0] q_q;

  logic [CW-1:0] nbx, nby, nbz;
  logic [AW-1:0] site_addr, nb_addr, q_addr, rd_addr, wr_addr;
  logic [1:0]    wr_data;
  logic          wr_en, rd_en;
  logic [31:0]   v1, v2, draw;
  logic          cand, join_nb;
  logic signed [2:0] ed;

  function automatic logic [CW-1:0] reduce(input logic [icfe_pkg::COORD_W-1:0] v);
    logic [7:0] t;
    t = 8'(v);
    for (int i = 0; i < 8; i++) begin
      if (t >= 8'(SIDE)) t = t - 8'(SIDE);
    end
    return CW'(t);
  endfunction

  function automatic logic [CW-1:0] up(input logic [CW-1:0] c);
    return (c == CW'(SIDE - 1)) ? '0 : c + CW'(1);
  endfunction

  function automatic logic [CW-1:0] down(input logic [CW-1:0] c);
    return (c == '0) ? CW'(SIDE - 1) : c - CW'(1);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] ax,
                                            input logic [CW-1:0] ay,
                                            input logic [CW-1:0] az);
    return (AW'(ax) * AW'(SIDE) + AW'(ay)) * AW'(SIDE) + AW'(az);
  endfunction

  always_comb begin
    nbx = cx;
    nby = cy;
    nbz = cz;
    case (dir)
      3'd0: nbx = up(cx);
      3'd1: nbx = down(cx);
      3'd2: nby = up(cy);
      3'd3: nby = down(cy);
      3'd4: nbz = up(cz);
      3'd5: nbz = down(cz);
      default: nbx = cx;
    endcase
  end

  assign site_addr = addr_of(sx, sy, sz);
  assign nb_addr = addr_of(nbx, nby, nbz);
  assign q_addr = addr_of(q_q[QW-1 -: CW], q_q[2*CW-1 -: CW], q_q[CW-1:0]);

  // xorshift32 step
  assign v1 = rng_word ^ (rng_word << 13);
  assign v2 = v1 ^ (v1 >> 17);
  assign draw = v2 ^ (v2 << 5);

  assign cand = cmd.nb_chk && !mem_q[1] && (mem_q[0] == cspin);
  assign join_nb = cand && (draw < thresh);

  always_comb begin
    rd_en = cmd.rd_site || cmd.nb_rd || cmd.m_rd;
    rd_addr = site_addr;
    if (cmd.nb_rd) begin
      rd_addr = nb_addr;
    end else if (cmd.m_rd) begin
      case (cmd.m_sel)
        2'd0:    rd_addr = addr_of(mx, my, mz);
        2'd1:    rd_addr = addr_of(up(mx), my, mz);
        2'd2:    rd_addr = addr_of(mx, up(my), mz);
        default: rd_addr = addr_of(mx, my, up(mz));
      endcase
    end
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = site_addr;
    wr_data = 2'b00;
    if (cmd.clr_wr) begin
      wr_en = 1'b1;
      wr_addr = clr_cnt;
      wr_data = 2'b01;
    end else if (cmd.wr_spin) begin
      wr_en = 1'b1;
      wr_data = {1'b0, spin_r};
    end else if (cmd.seed_wr) begin
      wr_en = 1'b1;
      wr_data = {1'b1, mem_q[0]};
    end else if (join_nb) begin
      wr_en = 1'b1;
      wr_addr = nb_addr;
      wr_data = {1'b1, cspin};
    end else if (cmd.flip_wr) begin
      // flipping also clears the visited mark for the next update
      wr_en = 1'b1;
      wr_addr = q_addr;
      wr_data = {1'b0, ~cspin};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) lat_mem[wr_addr] <= wr_data;
    if (rd_en) mem_q <= lat_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.seed_wr) begin
      queue_mem[0] <= {sx, sy, sz};
    end else if (join_nb && (tail < CNTW'(NS))) begin
      queue_mem[tail[AW-1:0]] <= {nbx, nby, nbz};
    end
    if (cmd.pop_rd) q_q <= queue_mem[head[AW-1:0]];
    else if (cmd.flip_rd) q_q <= queue_mem[k[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= icfe_pkg::THRESH_RST;
      rng_word <= icfe_pkg::SEED_RST;
    end else if (cfg_valid) begin
      if (cfg_index == icfe_pkg::CFG_THRESH) thresh <= cfg_data;
      else if (cfg_index == icfe_pkg::CFG_SEED) rng_word <= cfg_data;
    end else if (cand) begin
      rng_word <= draw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r <= kind;
      sx <= reduce(site_x);
      sy <= reduce(site_y);
      sz <= reduce(site_z);
      spin_r <= spin_in;
      head <= '0;
      k <= '0;
      mx <= '0;
      my <= '0;
      mz <= '0;
      mag <= '0;
      eng <= '0;
    end
    if (cmd.seed_wr) begin
      cspin <= mem_q[0];
      tail <= CNTW'(1);
    end else if (join_nb && (tail < CNTW'(NS))) begin
      tail <= tail + CNTW'(1);
    end
    if (cmd.pop_take) begin
      {cx, cy, cz} <= q_q;
      head <= head + CNTW'(1);
      dir <= 3'd0;
    end
    if (cmd.nb_chk) dir <= dir + 3'd1;
    if (cmd.flip_wr) k <= k + CNTW'(1);
    if (cmd.m_rd) begin
      case (cmd.m_sel)
        2'd1:    s_q <= mem_q[0];
        2'd2:    nx_q <= mem_q[0];
        2'd3:    ny_q <= mem_q[0];
        default: s_q <= s_q;
      endcase
    end
    if (cmd.m_acc) begin
      mag <= s_q ? mag + icfe_pkg::MAG_W'(1) : mag - icfe_pkg::MAG_W'(1);
      eng <= eng + {{(icfe_pkg::ENG_W - 3){ed[2]}}, ed};
      mz <= up(mz);
      if (mz == CW'(SIDE - 1)) begin
        my <= up(my);
        if (my == CW'(SIDE - 1)) mx <= up(mx);
      end
    end
  end

  // equal neighbours give -1, unequal +1, three forward bonds
  always_comb begin
    ed = 3'sd0;
    ed = ed + ((s_q == nx_q) ? -3'sd1 : 3'sd1);
    ed = ed + ((s_q == ny_q) ? -3'sd1 : 3'sd1);
    ed = ed + ((s_q == mem_q[0]) ? -3'sd1 : 3'sd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      spin_out <= (kind_r == icfe_pkg::KIND_RD) ? mem_q[0] : 1'b0;
      cluster_size <= (kind_r == icfe_pkg::KIND_UPD) ? icfe_pkg::SIZE_W'(tail) : '0;
      magnet_sum <= (kind_r == icfe_pkg::KIND_MEAS) ? mag : '0;
      bond_energy_sum <= (kind_r == icfe_pkg::KIND_MEAS) ? eng : '0;
    end
  end

  assign sts.clr_last = (clr_cnt == AW'(NS - 1));
  assign sts.queue_empty = (head == tail);
  assign sts.dir_last = (dir == 3'd5);
  assign sts.k_last = ((k + CNTW'(1)) == tail);
  assign sts.site_last = (mx == CW'(SIDE - 1)) && (my == CW'(SIDE - 1)) &&
                         (mz == CW'(SIDE - 1));
  assign sts.out_free = !out_valid || out_ready;

endmodule

### hdl/ising_cluster_flip_engine.sv
// Wolff cluster engine for a periodic SIDE^3 lattice of one-bit spins.
// Input channel in_valid/in_ready takes one item (kind, site, spin_in); the
// output channel out_valid/out_ready returns exactly one result per item.
// Configuration channel cfg_valid/cfg_ready is always ready: index 0 is the
// bond threshold, index 1 the generator seed, other indexes are ignored.
// Steps from accept to out_valid:
//   write spin and read spin make one access each; cluster update reads
//   and marks the seed, then per site pops the queue (S_POP, S_POP_TAKE),
//   makes six neighbour probes of a read and a check, then flips every
//   cluster site; measure makes four reads and one add per site.
// One item is in work at a time; the next can be taken while the result
// sits in the output register, and a stalled receiver holds back only
// the item after, which waits in S_FIN until the output is free.
// Reset clears control, loads threshold and seed, then sweeps the lattice
// setting every spin up and every visited mark clear, with in_ready low.
// A stalled output keeps its payload until taken.
module ising_cluster_flip_engine #(
  parameter int SIDE = icfe_pkg::SIDE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           kind,
  input  logic [icfe_pkg::COORD_W-1:0]         site_x,
  input  logic [icfe_pkg::COORD_W-1:0]         site_y,
  input  logic [icfe_pkg::COORD_W-1:0]         site_z,
  input  logic                                 spin_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 spin_out,
  output logic [icfe_pkg::SIZE_W-1:0]          cluster_size,
  output logic signed [icfe_pkg::MAG_W-1:0]    magnet_sum,
  output logic signed [icfe_pkg::ENG_W-1:0]    bond_energy_sum,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [icfe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [icfe_pkg::CFG_DATA_W-1:0]      cfg_data
);

  icfe_pkg::cmd_t cmd;
  icfe_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  icfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .sts      (sts),
    .cmd      (cmd)
  );

  icfe_dpath #(
    .SIDE (SIDE)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .kind            (kind),
    .site_x          (site_x),
    .site_y          (site_y),
    .site_z          (site_z),
    .spin_in         (spin_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .spin_out        (spin_out),
    .cluster_size    (cluster_size),
    .magnet_sum      (magnet_sum),
    .bond_energy_sum (bond_energy_sum),
    .cfg_valid       (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

endmodule

### hdl/icfe_checker.sv
`include "assert_macros.svh"

module icfe_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic [1:0]                           kind,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic                                 spin_out,
  input logic [icfe_pkg::SIZE_W-1:0]          cluster_size,
  input logic signed [icfe_pkg::MAG_W-1:0]    magnet_sum,
  input logic signed [icfe_pkg::ENG_W-1:0]    bond_energy_sum
);

  logic [1:0] kind_q;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) kind_q <= kind;
  end

  `ASSERT_CLK_ALWAYS(a_rst_idle, rst |=> !out_valid, "output valid after reset")

  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(cluster_size),
    "stalled result changed")

  // checked when a fresh result shows, before kind_q takes the next item
  `ASSERT_CLK(a_spin_zero,
    out_valid && !$past(out_valid && !out_ready) |->
      spin_out == 1'b0 || kind_q == icfe_pkg::KIND_RD,
    "spin field set on a non-read item")

  `ASSERT_CLK(a_sums_zero,
    out_valid && !$past(out_valid && !out_ready) |->
      (magnet_sum == '0 && bond_energy_sum == '0) || kind_q == icfe_pkg::KIND_MEAS,
    "sums set on a non-measure item")

endmodule

bind ising_cluster_flip_engine icfe_checker u_icfe_checker (.*);
